@@ design/trqs_pkg.sv @@
// Shared constants, types and codes for the Toeplitz RSS queue selector.
package trqs_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BYTES = 20;
    localparam int KEY_WORDS = 5;
    localparam int HASH_W = 32;
    localparam int QUEUE_W = 16;
    localparam int ENTRY_W = 7;
    localparam int TSIZE_W = 8;
    localparam int KLEN_CFG_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int KEY_FLAT_W = 32 * KEY_WORDS;
    localparam int TBL_IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KOFF_W = $clog2(KEY_BYTES + 1);
    localparam int WIN_BYTES = HASH_W / 8 + 1;
    localparam int WIN_W = 8 * WIN_BYTES;
    localparam int STEP_W = $clog2(HASH_W);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 3'd6;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_TABLE = 1'b1;

    localparam logic [0:KEY_WORDS-1][31:0] KEY_RESET = '{
        32'h6D5A566B, 32'h654E676E, 32'h67556A6B, 32'h614F6B65, 32'h6F494D42
    };
    localparam logic [KLEN_CFG_W-1:0] KEY_LENGTH_RESET = 5'd20;
    localparam logic [TSIZE_W-1:0] TABLE_SIZE_RESET = 8'd128;

    typedef struct packed {
        logic                op;
        logic [7:0]          data_byte;
        logic                last;
        logic [ENTRY_W-1:0]  entry_index;
        logic [QUEUE_W-1:0]  entry_queue;
    } trqs_item_t;

    typedef struct packed {
        logic [HASH_W-1:0]  flow_hash;
        logic [QUEUE_W-1:0] queue;
    } trqs_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_DELIVER
    } trqs_state_t;

    typedef struct packed {
        logic byte_en;
        logic msg_end;
        logic off_fix;
        logic div_step;
        logic tbl_wr;
        logic tbl_rd;
        logic out_load;
    } trqs_cmd_t;

    typedef struct packed {
        logic off_bad;
    } trqs_status_t;

endpackage

@@ design/trqs_table.sv @@
// Indirection table memory with per-entry valid bits and a registered read port.
module trqs_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [trqs_pkg::ENTRY_W-1:0]        wr_entry,
    input  logic [trqs_pkg::QUEUE_W-1:0]        wr_queue,
    input  logic                                rd_en,
    input  logic [trqs_pkg::TBL_IDX_W-1:0]      rd_idx,
    output logic [trqs_pkg::QUEUE_W-1:0]        rd_queue
);

    logic [trqs_pkg::QUEUE_W-1:0]     mem [trqs_pkg::TABLE_DEPTH];
    logic [trqs_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [trqs_pkg::QUEUE_W-1:0]     rd_data_reg;
    logic                             rd_valid_reg;
    logic                             wr_hit;
    logic [trqs_pkg::TBL_IDX_W-1:0]   wr_idx;

    assign wr_hit = wr_en && (32'(wr_entry) < 32'(trqs_pkg::TABLE_DEPTH));
    assign wr_idx = trqs_pkg::TBL_IDX_W'(wr_entry);

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_idx] <= wr_queue;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_queue = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/trqs_dpath.sv @@
// Datapath: key and table-size registers, hash accumulator, remainder unit and output register.
module trqs_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  trqs_pkg::trqs_cmd_t                 cmd,
    output trqs_pkg::trqs_status_t              status,
    input  logic                                cfg_wr_en,
    input  logic [trqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trqs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  trqs_pkg::trqs_item_t                item,
    output logic [trqs_pkg::TBL_IDX_W-1:0]      tbl_rd_idx,
    input  logic [trqs_pkg::QUEUE_W-1:0]        tbl_rd_queue,
    output trqs_pkg::trqs_result_t              result
);

    logic [0:trqs_pkg::KEY_WORDS-1][31:0] key_reg, key_next;
    logic [trqs_pkg::KLEN_CFG_W-1:0]      klen_reg, klen_next;
    logic [trqs_pkg::TSIZE_W-1:0]         tsize_reg, tsize_next;
    logic [trqs_pkg::HASH_W-1:0]          hash_reg, hash_next;
    logic [trqs_pkg::KOFF_W-1:0]          off_reg, off_next;
    logic [trqs_pkg::HASH_W-1:0]          final_hash_reg, final_hash_next;
    logic [trqs_pkg::HASH_W-1:0]          shift_reg, shift_next;
    logic [trqs_pkg::TSIZE_W-1:0]         rem_reg, rem_next;
    trqs_pkg::trqs_result_t               result_reg, result_next;

    logic [trqs_pkg::KOFF_W-1:0]          klen_eff;
    logic [trqs_pkg::TSIZE_W-1:0]         tsize_eff;
    logic [trqs_pkg::KEY_FLAT_W-1:0]      key_flat;
    logic [trqs_pkg::KOFF_W-1:0]          bidx [trqs_pkg::WIN_BYTES];
    logic [trqs_pkg::WIN_W-1:0]           window;
    logic [trqs_pkg::HASH_W-1:0]          contrib;
    logic [trqs_pkg::HASH_W-1:0]          hash_upd;
    logic [trqs_pkg::TSIZE_W:0]           trial;

    assign key_flat = key_reg;

    assign klen_eff = (32'(klen_reg) > 32'(trqs_pkg::KEY_BYTES))
                      ? trqs_pkg::KOFF_W'(trqs_pkg::KEY_BYTES)
                      : trqs_pkg::KOFF_W'(klen_reg);

    assign tsize_eff = (tsize_reg == '0) ? trqs_pkg::TSIZE_W'(1)
                     : (32'(tsize_reg) > 32'(trqs_pkg::TABLE_DEPTH))
                       ? trqs_pkg::TSIZE_W'(trqs_pkg::TABLE_DEPTH)
                       : tsize_reg;

    assign status.off_bad = (klen_eff != '0) && (off_reg >= klen_eff);

    // Key window of the next byte: five key bytes starting at the byte offset, wrapping.
    always_comb
    begin
        bidx[0] = off_reg;
        for (int m = 1; m < trqs_pkg::WIN_BYTES; m++)
        begin
            bidx[m] = (trqs_pkg::KOFF_W'(bidx[m-1] + 1'b1) == klen_eff)
                      ? '0 : trqs_pkg::KOFF_W'(bidx[m-1] + 1'b1);
        end
        window = '0;
        for (int m = 0; m < trqs_pkg::WIN_BYTES; m++)
        begin
            window[trqs_pkg::WIN_W-1-8*m -: 8] =
                key_flat[trqs_pkg::KEY_FLAT_W-1-8*int'(bidx[m]) -: 8];
        end
        contrib = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (item.data_byte[7-i])
            begin
                contrib = contrib ^ window[trqs_pkg::WIN_W-1-i -: trqs_pkg::HASH_W];
            end
        end
    end

    assign hash_upd = (klen_eff == '0) ? hash_reg : (hash_reg ^ contrib);

    always_comb
    begin
        key_next = key_reg;
        klen_next = klen_reg;
        tsize_next = tsize_reg;
        hash_next = hash_reg;
        off_next = off_reg;
        final_hash_next = final_hash_reg;
        shift_next = shift_reg;
        rem_next = rem_reg;
        result_next = result_reg;
        trial = {rem_reg, shift_reg[trqs_pkg::HASH_W-1]};

        if (cfg_wr_en)
        begin
            if (cfg_index < trqs_pkg::CFG_IDX_W'(trqs_pkg::KEY_WORDS))
            begin
                key_next[cfg_index] = cfg_data[31:0];
            end
            else if (cfg_index == trqs_pkg::CFG_KEY_LENGTH)
            begin
                klen_next = cfg_data[trqs_pkg::KLEN_CFG_W-1:0];
            end
            else if (cfg_index == trqs_pkg::CFG_TABLE_SIZE)
            begin
                tsize_next = cfg_data[trqs_pkg::TSIZE_W-1:0];
            end
        end

        if (cmd.off_fix)
        begin
            off_next = off_reg - klen_eff;
        end

        if (cmd.byte_en)
        begin
            hash_next = hash_upd;
            off_next = (klen_eff == '0) ? '0 : bidx[1];
        end

        if (cmd.msg_end)
        begin
            final_hash_next = hash_upd;
            shift_next = hash_upd;
            rem_next = '0;
            hash_next = '0;
            off_next = '0;
        end

        // Restoring remainder, one hash bit per step, most significant first.
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, tsize_eff})
            begin
                rem_next = trqs_pkg::TSIZE_W'(trial - {1'b0, tsize_eff});
            end
            else
            begin
                rem_next = trial[trqs_pkg::TSIZE_W-1:0];
            end
            shift_next = shift_reg << 1;
        end

        if (cmd.out_load)
        begin
            result_next.flow_hash = final_hash_reg;
            result_next.queue = tbl_rd_queue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= trqs_pkg::KEY_RESET;
            klen_reg <= trqs_pkg::KEY_LENGTH_RESET;
            tsize_reg <= trqs_pkg::TABLE_SIZE_RESET;
            hash_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            klen_reg <= klen_next;
            tsize_reg <= tsize_next;
            hash_reg <= hash_next;
            off_reg <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        final_hash_reg <= final_hash_next;
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        result_reg <= result_next;
    end

    assign tbl_rd_idx = trqs_pkg::TBL_IDX_W'(rem_reg);
    assign result = result_reg;

endmodule

@@ design/trqs_ctrl.sv @@
// Controller: sequences byte intake, the remainder steps, the table read and result delivery.
module trqs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_op,
    input  logic                   item_last,
    output logic                   item_stall,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  trqs_pkg::trqs_status_t status,
    output trqs_pkg::trqs_cmd_t    cmd
);

    trqs_pkg::trqs_state_t         state_reg, state_next;
    logic [trqs_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          fix_now;

    assign fix_now = item_valid && (item_op == trqs_pkg::OP_DATA) && status.off_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trqs_pkg::ST_IDLE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cmd = '0;
        item_stall = 1'b1;

        case (state_reg)
            trqs_pkg::ST_IDLE:
            begin
                item_stall = fix_now;
                cmd.off_fix = fix_now;
                if (item_valid && !fix_now)
                begin
                    if (item_op == trqs_pkg::OP_TABLE)
                    begin
                        cmd.tbl_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.byte_en = 1'b1;
                        if (item_last)
                        begin
                            cmd.msg_end = 1'b1;
                            step_next = '0;
                            state_next = trqs_pkg::ST_DIVIDE;
                        end
                    end
                end
            end
            trqs_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == trqs_pkg::STEP_W'(trqs_pkg::HASH_W - 1))
                begin
                    state_next = trqs_pkg::ST_READ;
                end
            end
            trqs_pkg::ST_READ:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = trqs_pkg::ST_DELIVER;
            end
            trqs_pkg::ST_DELIVER:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next = trqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trqs_pkg::ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

@@ design/toeplitz_rss_queue_select_unit.sv @@
// Top level of the Toeplitz RSS queue selector.
//
// The item channel carries message bytes (op data) and indirection table
// writes (op table). Each beat is accepted when item_valid is high and
// item_stall is low. Table writes and bytes that do not end a message
// stream at one beat per cycle while item_stall stays low.
// A byte marked last closes the message: the hash is reduced modulo the table
// size by a remainder unit that handles one hash bit per cycle, the table is
// read once, and the result is loaded into the output register and shown on
// result_valid. Item beats stay stalled until that load.
// The result sits in an output register; the block goes back to taking item
// beats while it waits there, and only the next finished message waits for a
// stalled receiver to take it.
// After key_length is written no higher than the current key byte offset
// (and not zero), the next data beat is stalled while the offset is
// brought back into range, one subtraction per cycle.
// Reset loads the default key, key_length 20 and table_size 128, clears the
// running hash and offset, and marks every table entry as zero.
module toeplitz_rss_queue_select_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  trqs_pkg::trqs_item_t              item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output trqs_pkg::trqs_result_t            result,
    input  logic                              cfg_wr_en,
    input  logic [trqs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trqs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    trqs_pkg::trqs_cmd_t               cmd;
    trqs_pkg::trqs_status_t            status;
    logic [trqs_pkg::TBL_IDX_W-1:0]    tbl_rd_idx;
    logic [trqs_pkg::QUEUE_W-1:0]      tbl_rd_queue;

    trqs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_op      (item.op),
        .item_last    (item.last),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    trqs_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .tbl_rd_idx   (tbl_rd_idx),
        .tbl_rd_queue (tbl_rd_queue),
        .result       (result)
    );

    trqs_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd.tbl_wr),
        .wr_entry (item.entry_index),
        .wr_queue (item.entry_queue),
        .rd_en    (cmd.tbl_rd),
        .rd_idx   (tbl_rd_idx),
        .rd_queue (tbl_rd_queue)
    );

endmodule
